/* hdl/led_rain_pkg.sv */
// Types and constants shared by the raindrop LED effect.
package led_rain_pkg;

    localparam int IDX_W   = 8;
    localparam int HUE_W   = 9;
    localparam int SAT_W   = 10;
    localparam int VAL_W   = 14;
    localparam int RAND_W  = 16;
    localparam int STORE_DEPTH = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANCE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_HIGH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LOW        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_HIGH       = 3'd7;

    // roll = (r * ROLL_SPAN) >> 16 lands in 0..10000
    localparam logic [VAL_W-1:0] ROLL_SPAN = 14'd10001;
    localparam logic [VAL_W-1:0] UNIT      = 14'd10000;

    // floor(p / 10000) = (p * RECIP_M) >> RECIP_SHIFT, exact for p < 2**28
    localparam int DPROD_W     = 2 * VAL_W;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 42;
    localparam logic [RECIP_W-1:0] RECIP_M = 29'd439804652;

    typedef struct packed {
        logic [IDX_W-1:0]  led_index;
        logic [HUE_W-1:0]  in_hue;
        logic [SAT_W-1:0]  in_sat;
        logic [VAL_W-1:0]  in_val;
        logic [RAND_W-1:0] rand_roll;
        logic [RAND_W-1:0] rand_hue;
        logic [RAND_W-1:0] rand_sat;
        logic [RAND_W-1:0] rand_val;
        logic [RAND_W-1:0] rand_decay;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] out_hue;
        logic [SAT_W-1:0] out_sat;
        logic [VAL_W-1:0] out_val;
    } color_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] decay;
    } drop_t;

endpackage

/* hdl/led_raindrop_effect.sv */
// Raindrop LED effect: per-LED drop store with read-modify-write pipeline.
//
//   channel   direction  handshake                  word
//   pixel     in         pixel_valid / pixel_stall  pixel_t
//   color     out        color_valid / color_stall  color_t
//   cfg       in         cfg_we                     cfg_index, cfg_data
//
// One word per clock when not stalled; color_valid_reg takes s1_valid_reg.
// The drop store is a 256-entry memory, read on accept, written back from
// stage two after the decay multiply and the divide by 10000.
// A word for the same LED as an active word in stage one waits until it leaves.
// Reset clears the store through per-entry valid bits, with no clearing pass.
// A stall on color holds the output word; pixel keeps flowing until stage one fills.
module led_raindrop_effect
    import led_rain_pkg::*;
#(
    parameter int LED_COUNT = 256,
    parameter int SAT_LOW   = 0,
    parameter int SAT_HIGH  = 1000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_t                pixel_data,
    output logic                  color_valid,
    input  logic                  color_stall,
    output color_t                color_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [SAT_W-1:0] SAT_LO   = SAT_W'(SAT_LOW);
    localparam logic [SAT_W:0]   SAT_SPAN = (SAT_LOW >= SAT_HIGH) ? '0 :
                                            (SAT_W+1)'(SAT_HIGH - SAT_LOW + 1);

    // configuration
    logic             effect_enable_reg;
    logic [VAL_W-1:0] chance_threshold_reg;
    logic [HUE_W-1:0] hue_low_reg, hue_high_reg;
    logic [VAL_W-1:0] value_low_reg, value_high_reg;
    logic [VAL_W-1:0] decay_low_reg, decay_high_reg;

    // store
    drop_t                  drop_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] drop_vld_reg;
    drop_t                  rd_reg;
    logic                   rd_vld_reg;

    // stage one
    logic             s1_valid_reg;
    logic             s1_act_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    color_t           s1_color_reg;
    logic [VAL_W-1:0] s1_roll_reg;
    logic [HUE_W:0]   s1_hue_off_reg;
    logic [SAT_W:0]   s1_sat_off_reg;
    logic [VAL_W:0]   s1_val_off_reg;
    logic [VAL_W:0]   s1_decay_off_reg;
    logic             s1_fwd_hit_reg;
    drop_t            s1_fwd_reg;

    // stage two (write-back)
    logic               s2_valid_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    drop_t              s2_ent_reg;
    logic [DPROD_W-1:0] s2_prod_reg;

    // output
    logic   color_valid_reg;
    color_t color_data_reg;

    logic                           accept;
    logic                           out_free;
    logic                           s1_move;
    logic                           hazard;
    logic                           in_range;
    logic [HUE_W:0]                 hue_span;
    logic [VAL_W:0]                 val_span;
    logic [VAL_W:0]                 decay_span;
    logic [RAND_W+VAL_W-1:0]        roll_prod;
    logic [RAND_W+HUE_W:0]          hue_prod;
    logic [RAND_W+SAT_W:0]          sat_prod;
    logic [RAND_W+VAL_W:0]          val_prod;
    logic [RAND_W+VAL_W:0]          decay_prod;
    drop_t                          base;
    drop_t                          ent;
    logic                           relight;
    logic [VAL_W-1:0]               decay_fac;
    logic [DPROD_W-1:0]             dec_prod;
    color_t                         color_next;
    logic [DPROD_W+RECIP_W-1:0]     q_full;
    drop_t                          wr_data;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_enable_reg    <= 1'b1;
            chance_threshold_reg <= 14'd9500;
            hue_low_reg          <= 9'd0;
            hue_high_reg         <= 9'd360;
            value_low_reg        <= 14'd8000;
            value_high_reg       <= 14'd10000;
            decay_low_reg        <= 14'd8000;
            decay_high_reg       <= 14'd5000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EFFECT_ENABLE:    effect_enable_reg    <= cfg_data[0];
                CFG_CHANCE_THRESHOLD: chance_threshold_reg <= cfg_data[VAL_W-1:0];
                CFG_HUE_LOW:          hue_low_reg          <= cfg_data[HUE_W-1:0];
                CFG_HUE_HIGH:         hue_high_reg         <= cfg_data[HUE_W-1:0];
                CFG_VALUE_LOW:        value_low_reg        <= cfg_data[VAL_W-1:0];
                CFG_VALUE_HIGH:       value_high_reg       <= cfg_data[VAL_W-1:0];
                CFG_DECAY_LOW:        decay_low_reg        <= cfg_data[VAL_W-1:0];
                CFG_DECAY_HIGH:       decay_high_reg       <= cfg_data[VAL_W-1:0];
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free    = !color_valid_reg || !color_stall;
    assign s1_move     = s1_valid_reg && out_free;
    assign hazard      = s1_valid_reg && s1_act_reg && (pixel_data.led_index == s1_idx_reg);
    assign pixel_stall = (s1_valid_reg && !out_free) || hazard;
    assign accept      = pixel_valid && !pixel_stall;
    assign color_valid = color_valid_reg;
    assign color_data  = color_data_reg;

    // ---------------- stage zero: spans and random products ----------------
    always_comb
    begin
        in_range   = (32'(pixel_data.led_index) < LED_COUNT);
        // empty or inverted range: span 0 leaves the low bound
        hue_span   = (hue_low_reg >= hue_high_reg) ? '0 :
                     ({1'b0, hue_high_reg} - {1'b0, hue_low_reg} + (HUE_W+1)'(1));
        val_span   = (value_low_reg >= value_high_reg) ? '0 :
                     ({1'b0, value_high_reg} - {1'b0, value_low_reg} + (VAL_W+1)'(1));
        decay_span = (decay_low_reg >= decay_high_reg) ? '0 :
                     ({1'b0, decay_high_reg} - {1'b0, decay_low_reg} + (VAL_W+1)'(1));
        roll_prod  = (RAND_W+VAL_W)'(pixel_data.rand_roll) * (RAND_W+VAL_W)'(ROLL_SPAN);
        hue_prod   = (RAND_W+HUE_W+1)'(pixel_data.rand_hue) * (RAND_W+HUE_W+1)'(hue_span);
        sat_prod   = (RAND_W+SAT_W+1)'(pixel_data.rand_sat) * (RAND_W+SAT_W+1)'(SAT_SPAN);
        val_prod   = (RAND_W+VAL_W+1)'(pixel_data.rand_val) * (RAND_W+VAL_W+1)'(val_span);
        decay_prod = (RAND_W+VAL_W+1)'(pixel_data.rand_decay) * (RAND_W+VAL_W+1)'(decay_span);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg           <= effect_enable_reg && in_range;
            s1_idx_reg           <= pixel_data.led_index;
            s1_color_reg.out_hue <= pixel_data.in_hue;
            s1_color_reg.out_sat <= pixel_data.in_sat;
            s1_color_reg.out_val <= pixel_data.in_val;
            s1_roll_reg          <= roll_prod[RAND_W +: VAL_W];
            s1_hue_off_reg       <= hue_prod[RAND_W +: HUE_W+1];
            s1_sat_off_reg       <= sat_prod[RAND_W +: SAT_W+1];
            s1_val_off_reg       <= val_prod[RAND_W +: VAL_W+1];
            s1_decay_off_reg     <= decay_prod[RAND_W +: VAL_W+1];
            // write-back landing on this edge is not seen by the read
            s1_fwd_hit_reg       <= s2_valid_reg && (s2_idx_reg == pixel_data.led_index);
            s1_fwd_reg           <= wr_data;
            rd_reg               <= drop_mem[pixel_data.led_index];
            rd_vld_reg           <= drop_vld_reg[pixel_data.led_index];
        end
    end

    // ---------------- stage one: relight, output, decay multiply ----------------
    always_comb
    begin
        base = s1_fwd_hit_reg ? s1_fwd_reg : (rd_vld_reg ? rd_reg : '0);
        relight = (s1_roll_reg >= chance_threshold_reg);
        ent = base;
        if (relight)
        begin
            ent.hue   = HUE_W'({1'b0, hue_low_reg} + s1_hue_off_reg);
            ent.sat   = SAT_W'({1'b0, SAT_LO} + s1_sat_off_reg);
            ent.val   = VAL_W'({1'b0, value_low_reg} + s1_val_off_reg);
            ent.decay = VAL_W'({1'b0, decay_low_reg} + s1_decay_off_reg);
        end
        decay_fac = (ent.decay > UNIT) ? UNIT : ent.decay;
        dec_prod  = DPROD_W'(ent.val) * DPROD_W'(decay_fac);
        if (s1_act_reg)
        begin
            color_next.out_hue = ent.hue;
            color_next.out_sat = ent.sat;
            color_next.out_val = ent.val;
        end
        else
        begin
            color_next = s1_color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_valid_reg <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                color_valid_reg <= s1_valid_reg;
            end
            s2_valid_reg <= s1_move && s1_act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            color_data_reg <= color_next;
            s2_idx_reg     <= s1_idx_reg;
            s2_ent_reg     <= ent;
            s2_prod_reg    <= dec_prod;
        end
    end

    // ---------------- stage two: divide by 10000, write back ----------------
    always_comb
    begin
        q_full      = (DPROD_W+RECIP_W)'(s2_prod_reg) * (DPROD_W+RECIP_W)'(RECIP_M);
        wr_data     = s2_ent_reg;
        wr_data.val = q_full[RECIP_SHIFT +: VAL_W];
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            drop_mem[s2_idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_vld_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            drop_vld_reg[s2_idx_reg] <= 1'b1;
        end
    end

endmodule

/* verif/raindrop_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks the colors of the raindrop LED effect.
`timescale 1ns / 1ps
package raindrop_scoreboard_pkg;
    import led_rain_pkg::*;

    localparam int unsigned LED_COUNT  = 256;
    localparam int unsigned SAT_LOW    = 0;
    localparam int unsigned SAT_HIGH   = 1000;
    localparam int unsigned ROLL_MAX   = 10000;
    localparam int unsigned DECAY_UNIT = 10000;

    class raindrop_scoreboard;
        logic [CFG_DATA_W-1:0] regs_model [8];
        drop_t                 drops [STORE_DEPTH];
        color_t                expected_colors [$];
        int                    errors;

        function new();
            regs_model[CFG_EFFECT_ENABLE]    = 14'd1;
            regs_model[CFG_CHANCE_THRESHOLD] = 14'd9500;
            regs_model[CFG_HUE_LOW]          = 14'd0;
            regs_model[CFG_HUE_HIGH]         = 14'd360;
            regs_model[CFG_VALUE_LOW]        = 14'd8000;
            regs_model[CFG_VALUE_HIGH]       = 14'd10000;
            regs_model[CFG_DECAY_LOW]        = 14'd8000;
            regs_model[CFG_DECAY_HIGH]       = 14'd5000;
            foreach (drops[i])
                drops[i] = '0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EFFECT_ENABLE:         regs_model[idx] = data & 14'h1;
                CFG_HUE_LOW, CFG_HUE_HIGH: regs_model[idx] = data & 14'h1FF;
                default:                   regs_model[idx] = data;
            endcase
        endfunction

        function int unsigned draw_in_range(int unsigned lo, int unsigned hi,
                                            logic [RAND_W-1:0] word);
            longint unsigned span;
            if (lo >= hi)
                return lo;
            span = 64'(hi - lo) + 64'd1;
            return lo + 32'((64'(word) * span) >> 16);
        endfunction

        function color_t predict_color(pixel_t p);
            color_t      c;
            drop_t       d;
            int unsigned roll;
            int unsigned factor;
            if (regs_model[CFG_EFFECT_ENABLE][0] == 1'b0 || 32'(p.led_index) >= LED_COUNT)
            begin
                c.out_hue = p.in_hue;
                c.out_sat = p.in_sat;
                c.out_val = p.in_val;
                return c;
            end
            d    = drops[p.led_index];
            roll = draw_in_range(0, ROLL_MAX, p.rand_roll);
            if (roll >= 32'(regs_model[CFG_CHANCE_THRESHOLD]))
            begin
                d.hue   = HUE_W'(draw_in_range(32'(regs_model[CFG_HUE_LOW]),
                                               32'(regs_model[CFG_HUE_HIGH]), p.rand_hue));
                d.sat   = SAT_W'(draw_in_range(SAT_LOW, SAT_HIGH, p.rand_sat));
                d.val   = VAL_W'(draw_in_range(32'(regs_model[CFG_VALUE_LOW]),
                                               32'(regs_model[CFG_VALUE_HIGH]), p.rand_val));
                d.decay = VAL_W'(draw_in_range(32'(regs_model[CFG_DECAY_LOW]),
                                               32'(regs_model[CFG_DECAY_HIGH]), p.rand_decay));
            end
            c.out_hue = d.hue;
            c.out_sat = d.sat;
            c.out_val = d.val;
            // decay factor saturates at unity
            factor = (32'(d.decay) > DECAY_UNIT) ? DECAY_UNIT : 32'(d.decay);
            d.val  = VAL_W'((64'(d.val) * 64'(factor)) / 64'(DECAY_UNIT));
            drops[p.led_index] = d;
            return c;
        endfunction

        function void note_pixel(pixel_t p);
            expected_colors.push_back(predict_color(p));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want == got)
                return;
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        endfunction

        function void check_color(color_t got);
            color_t want;
            if (expected_colors.size() == 0)
            begin
                errors++;
                $display("%0t: color word with none expected, got %0d/%0d/%0d",
                         $time, got.out_hue, got.out_sat, got.out_val);
                return;
            end
            want = expected_colors.pop_front();
            compare_field("out_hue", 32'(want.out_hue), 32'(got.out_hue));
            compare_field("out_sat", 32'(want.out_sat), 32'(got.out_sat));
            compare_field("out_val", 32'(want.out_val), 32'(got.out_val));
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

endpackage

/* verif/tb_led_raindrop_effect.sv */
// Testbench top for the raindrop LED effect: directed and random pixel words checked per field.
`timescale 1ns / 1ps
module tb_led_raindrop_effect;
    import led_rain_pkg::*;
    import raindrop_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 116;
    localparam int SETTLE_CYCLES   = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    pixel_t                pixel_data = '0;
    logic                  color_valid;
    logic                  color_stall = 1'b0;
    color_t                color_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [CFG_DATA_W-1:0] regs [8];
    int                    gap_table [4]   = '{0, 77, 0, 20};
    int                    stall_table [4] = '{0, 0, 77, 20};
    int                    gap_pct = 0;
    int                    stall_pct = 0;
    int                    idle_cycles = 0;
    logic [IDX_W-1:0]      last_index = '0;
    raindrop_scoreboard    rain_sb;

    led_raindrop_effect dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        color_stall <= (stall_pct != 0) && (int'($urandom_range(99)) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
                rain_sb.note_pixel(pixel_data);
            if (color_valid && !color_stall)
                rain_sb.check_color(color_data);
            if ((pixel_valid && !pixel_stall) || (color_valid && !color_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no word accepted for %0d cycles", $time, idle_cycles);
                $display("[led_raindrop_effect] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic pixel_t make_pixel(logic [IDX_W-1:0] idx, logic [HUE_W-1:0] hue,
                                          logic [SAT_W-1:0] sat, logic [VAL_W-1:0] val,
                                          logic [RAND_W-1:0] roll, logic [RAND_W-1:0] word,
                                          logic [RAND_W-1:0] decay_word);
        pixel_t p;
        p.led_index  = idx;
        p.in_hue     = hue;
        p.in_sat     = sat;
        p.in_val     = val;
        p.rand_roll  = roll;
        p.rand_hue   = word;
        p.rand_sat   = word;
        p.rand_val   = word;
        p.rand_decay = decay_word;
        return p;
    endfunction

    function automatic logic [RAND_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return RAND_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_bound(int unsigned top,
                                                            int unsigned field_top);
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(top);
            2:       return CFG_DATA_W'(field_top);
            default: return CFG_DATA_W'($urandom_range(top));
        endcase
    endfunction

    task automatic reconfigure();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (rain_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= regs[i];
            @(posedge clk);
            rain_sb.set_register(CFG_IDX_W'(i), regs[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(pixel_t p, bit drain);
        if (drain || int'($urandom_range(99)) < gap_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
            while (drain && rain_sb.pending() != 0)
                @(posedge clk);
            while (int'($urandom_range(99)) < gap_pct)
                @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data  <= p;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    initial
    begin
        rain_sb = new();
        regs[CFG_EFFECT_ENABLE]    = 14'd1;
        regs[CFG_CHANCE_THRESHOLD] = 14'd9500;
        regs[CFG_HUE_LOW]          = 14'd0;
        regs[CFG_HUE_HIGH]         = 14'd360;
        regs[CFG_VALUE_LOW]        = 14'd8000;
        regs[CFG_VALUE_HIGH]       = 14'd10000;
        regs[CFG_DECAY_LOW]        = 14'd8000;
        regs[CFG_DECAY_HIGH]       = 14'd5000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: relight, fade, never-lit LED
        send_pixel(make_pixel(8'd0, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'h0000, 16'h0000), 1'b0);
        send_pixel(make_pixel(8'd0, 9'd0, 10'd0, 14'd0, 16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_pixel(make_pixel(8'd255, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd255, 9'd0, 10'd0, 14'd0, 16'h0000, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd7, 9'd360, 10'd1000, 14'd10000, 16'h0000, 16'hFFFF, 16'hFFFF),
                   1'b0);

        // disabled: colors pass through, store untouched
        regs[CFG_EFFECT_ENABLE] = 14'd0;
        reconfigure();
        send_pixel(make_pixel(8'd0, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd255, 9'h1FF, 10'h3FF, 14'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                   1'b0);
        send_pixel(make_pixel(8'd128, 9'd360, 10'd1000, 14'd10000, 16'h0000, 16'h0000, 16'h0000),
                   1'b0);

        // zero threshold, inverted and empty ranges, decay above unity
        regs[CFG_EFFECT_ENABLE]    = 14'd1;
        regs[CFG_CHANCE_THRESHOLD] = 14'd0;
        regs[CFG_HUE_LOW]          = 14'd360;
        regs[CFG_HUE_HIGH]         = 14'd0;
        regs[CFG_VALUE_LOW]        = 14'd10000;
        regs[CFG_VALUE_HIGH]       = 14'd10000;
        regs[CFG_DECAY_LOW]        = 14'h3FFF;
        regs[CFG_DECAY_HIGH]       = 14'd0;
        reconfigure();
        send_pixel(make_pixel(8'd3, 9'd0, 10'd0, 14'd0, 16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_pixel(make_pixel(8'd3, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd3, 9'd0, 10'd0, 14'd0, 16'h0000, 16'h8000, 16'h8000), 1'b0);

        // threshold out of reach
        regs[CFG_CHANCE_THRESHOLD] = 14'h3FFF;
        regs[CFG_HUE_LOW]          = 14'd0;
        regs[CFG_HUE_HIGH]         = 14'h1FF;
        regs[CFG_VALUE_LOW]        = 14'd0;
        regs[CFG_VALUE_HIGH]       = 14'h3FFF;
        regs[CFG_DECAY_LOW]        = 14'd0;
        regs[CFG_DECAY_HIGH]       = 14'd10000;
        reconfigure();
        send_pixel(make_pixel(8'd3, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd255, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);

        // threshold at the top of the roll, hue and brightness beyond their ranges
        regs[CFG_CHANCE_THRESHOLD] = 14'd10000;
        reconfigure();
        send_pixel(make_pixel(8'd5, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd5, 9'd0, 10'd0, 14'd0, 16'd65000, 16'h0000, 16'h0000), 1'b0);
        send_pixel(make_pixel(8'd5, 9'd0, 10'd0, 14'd0, 16'hFFFF, 16'hFFFF, 16'h0000), 1'b0);
        send_pixel(make_pixel(8'd5, 9'd0, 10'd0, 14'd0, 16'h0000, 16'h0000, 16'h0000), 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            regs[CFG_EFFECT_ENABLE]    = CFG_DATA_W'($urandom_range(7) != 0);
            regs[CFG_CHANCE_THRESHOLD] = random_bound(10000, 16383);
            regs[CFG_HUE_LOW]          = random_bound(360, 511);
            regs[CFG_HUE_HIGH]         = random_bound(360, 511);
            regs[CFG_VALUE_LOW]        = random_bound(10000, 16383);
            regs[CFG_VALUE_HIGH]       = random_bound(10000, 16383);
            regs[CFG_DECAY_LOW]        = random_bound(10000, 16383);
            regs[CFG_DECAY_HIGH]       = random_bound(10000, 16383);
            gap_pct   = 0;
            stall_pct = stall_table[phase % 4];
            reconfigure();
            gap_pct   = gap_table[phase % 4];
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                pixel_t p;
                // bias toward a few LEDs so back-to-back hits on one drop are common
                case ($urandom_range(9))
                    0, 1, 2, 3: p.led_index = IDX_W'($urandom_range(3));
                    4:          p.led_index = last_index;
                    default:    p.led_index = IDX_W'($urandom_range(255));
                endcase
                if ($urandom_range(9) == 0)
                begin
                    p.in_hue = HUE_W'($urandom_range(9'h1FF));
                    p.in_sat = SAT_W'($urandom_range(10'h3FF));
                    p.in_val = VAL_W'($urandom_range(14'h3FFF));
                end
                else
                begin
                    p.in_hue = HUE_W'($urandom_range(360));
                    p.in_sat = SAT_W'($urandom_range(1000));
                    p.in_val = VAL_W'($urandom_range(10000));
                end
                p.rand_roll  = random_word();
                p.rand_hue   = random_word();
                p.rand_sat   = random_word();
                p.rand_val   = random_word();
                p.rand_decay = random_word();
                last_index   = p.led_index;
                send_pixel(p, (phase == 1 && n == 40) || $urandom_range(59) == 0);
            end
        end

        pixel_valid <= 1'b0;
        @(posedge clk);
        while (rain_sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (rain_sb.errors == 0)
            $display("[led_raindrop_effect] OK");
        else
            $display("[led_raindrop_effect] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/led_rain_pkg.sv
hdl/led_raindrop_effect.sv
verif/raindrop_scoreboard_pkg.sv
verif/tb_led_raindrop_effect.sv
